// ===== rtl/swr_pkg.sv =====
// Shared types and constants for the stop-and-wait reply waiter.
package swr_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] FIXED_ADDR = 8'h01;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_MAX_TRIES     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_ADDRESS_BYTE  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_REPLY_CODES   = 2'd3;

  // Reply code slots inside reply_codes, one byte each.
  localparam int unsigned CODE_UA   = 0;
  localparam int unsigned CODE_RR0  = 1;
  localparam int unsigned CODE_RR1  = 2;
  localparam int unsigned CODE_REJ0 = 3;
  localparam int unsigned CODE_REJ1 = 4;
  localparam int unsigned CODE_DISC = 5;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    RS_START = 3'd0,
    RS_FLAG  = 3'd1,
    RS_ADDR  = 3'd2,
    RS_CTRL  = 3'd3,
    RS_BCC   = 3'd4
  } rs_e;

  typedef enum logic [2:0] {
    OC_UA        = 3'd0,
    OC_RR0       = 3'd1,
    OC_RR1       = 3'd2,
    OC_DISC      = 3'd3,
    OC_UNKNOWN   = 3'd4,
    OC_UA_SENT   = 3'd5,
    OC_EXHAUSTED = 3'd6
  } oc_e;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  max_tries;
    logic [7:0]  address_byte;
    logic [47:0] reply_codes;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] frame_control;
    logic [7:0] line_byte;
  } item_t;

  typedef struct packed {
    logic       transmit;
    logic       finished;
    logic [2:0] outcome;
  } result_t;

endpackage

// ===== rtl/swr_cfg.sv =====
// Configuration register file of the stop-and-wait reply waiter.
module swr_cfg
  import swr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= 16'd3;
      cfg_q.max_tries     <= 8'd3;
      cfg_q.address_byte  <= 8'd3;
      cfg_q.reply_codes   <= 48'h0B81_0185_0507;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[15:0];
        CFG_MAX_TRIES:     cfg_q.max_tries     <= cfg_data_i[7:0];
        CFG_ADDRESS_BYTE:  cfg_q.address_byte  <= cfg_data_i[7:0];
        CFG_REPLY_CODES:   cfg_q.reply_codes   <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/swr_in_reg.sv =====
// Input register slice that holds one accepted beat until the core takes it.
module swr_in_reg
  import swr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // The slot refills in the same cycle that the core takes its content.
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/swr_core.sv =====
// Exchange state, reply recognizer, retry timer and outcome classification.
module swr_core
  import swr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    has_result_o,
  output result_t result_o
);

  logic       waiting_q, waiting_d;
  rs_e        rs_q, rs_d;
  logic [7:0] seen_ctrl_q, seen_ctrl_d;
  logic [7:0] tries_q, tries_d;
  logic [15:0] ticks_q, ticks_d;

  logic [7:0] code [6];
  logic [7:0] tries_inc;
  logic       addr_hit;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      code[k] = cfg_i.reply_codes[8*k +: 8];
    end
  end

  assign tries_inc = tries_q + 8'd1;
  assign addr_hit  = (item_i.line_byte == cfg_i.address_byte) ||
                     (item_i.line_byte == FIXED_ADDR);

  always_comb begin
    waiting_d    = waiting_q;
    rs_d         = rs_q;
    seen_ctrl_d  = seen_ctrl_q;
    tries_d      = tries_q;
    ticks_d      = ticks_q;
    has_result_o = 1'b0;
    result_o     = '0;
    if (step_i) begin
      case (item_i.op)
        OP_START: begin
          tries_d      = 8'd0;
          rs_d         = RS_START;
          has_result_o = 1'b1;
          result_o.transmit = 1'b1;
          if (item_i.frame_control == code[CODE_UA]) begin
            // A UA frame needs no reply.
            waiting_d         = 1'b0;
            ticks_d           = 16'd0;
            result_o.finished = 1'b1;
            result_o.outcome  = OC_UA_SENT;
          end else begin
            waiting_d = 1'b1;
            ticks_d   = cfg_i.timeout_ticks;
          end
        end
        OP_BYTE: begin
          if (waiting_q) begin
            case (rs_q)
              RS_FLAG: begin
                // The address test comes before the flag test.
                if (addr_hit) begin
                  rs_d = RS_ADDR;
                end else if (item_i.line_byte == FLAG_BYTE) begin
                  rs_d = RS_FLAG;
                end else begin
                  rs_d = RS_START;
                end
              end
              RS_ADDR: begin
                if (item_i.line_byte == FLAG_BYTE) begin
                  rs_d = RS_FLAG;
                end else begin
                  rs_d        = RS_CTRL;
                  seen_ctrl_d = item_i.line_byte;
                end
              end
              RS_CTRL: begin
                rs_d = (item_i.line_byte == FLAG_BYTE) ? RS_FLAG : RS_BCC;
              end
              RS_BCC: begin
                rs_d = RS_START;
                if (item_i.line_byte == FLAG_BYTE) begin
                  has_result_o = 1'b1;
                  if (seen_ctrl_q != code[CODE_UA] && seen_ctrl_q != code[CODE_RR0] &&
                      seen_ctrl_q != code[CODE_RR1] &&
                      (seen_ctrl_q == code[CODE_REJ0] || seen_ctrl_q == code[CODE_REJ1])) begin
                    // Reject: resend at once without counting a try.
                    ticks_d           = cfg_i.timeout_ticks;
                    result_o.transmit = 1'b1;
                  end else begin
                    waiting_d         = 1'b0;
                    ticks_d           = 16'd0;
                    result_o.finished = 1'b1;
                    if (seen_ctrl_q == code[CODE_UA]) begin
                      result_o.outcome = OC_UA;
                    end else if (seen_ctrl_q == code[CODE_RR0]) begin
                      result_o.outcome = OC_RR0;
                    end else if (seen_ctrl_q == code[CODE_RR1]) begin
                      result_o.outcome = OC_RR1;
                    end else if (seen_ctrl_q == code[CODE_DISC]) begin
                      result_o.outcome = OC_DISC;
                    end else begin
                      result_o.outcome = OC_UNKNOWN;
                    end
                  end
                end
              end
              default: begin
                rs_d = (item_i.line_byte == FLAG_BYTE) ? RS_FLAG : RS_START;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (waiting_q) begin
            if (ticks_q > 16'd1) begin
              ticks_d = ticks_q - 16'd1;
            end else begin
              tries_d      = tries_inc;
              has_result_o = 1'b1;
              rs_d         = RS_START;
              if (tries_inc >= cfg_i.max_tries) begin
                waiting_d         = 1'b0;
                ticks_d           = 16'd0;
                result_o.finished = 1'b1;
                result_o.outcome  = OC_EXHAUSTED;
              end else begin
                ticks_d           = cfg_i.timeout_ticks;
                result_o.transmit = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      rs_q        <= RS_START;
      seen_ctrl_q <= 8'd0;
      tries_q     <= 8'd0;
      ticks_q     <= 16'd0;
    end else begin
      waiting_q   <= waiting_d;
      rs_q        <= rs_d;
      seen_ctrl_q <= seen_ctrl_d;
      tries_q     <= tries_d;
      ticks_q     <= ticks_d;
    end
  end

endmodule

// ===== rtl/swr_out_reg.sv =====
// Result register that holds a result beat until the downstream side takes it.
module swr_out_reg
  import swr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign space_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/stop_and_wait_reply_waiter_unit.sv =====
// Top level of the stop-and-wait reply waiter.
//
//   channel   direction  payload
//   s_axis    in         tuser: op; tdata: frame_control, line_byte
//   m_axis    out        tuser: transmit, finished; tdata: outcome
//   cfg       in         write only: cfg_we_i, cfg_idx_i, cfg_data_i
//
// An accepted beat is processed while it sits in the input register, and its
// result is loaded into the result register at the edge on which the core takes
// the beat from the input register.
// One beat is taken every cycle as long as the result register has room.
// A beat that produces no result still waits for that room.
// Reset clears the exchange state and loads the register defaults.
module stop_and_wait_reply_waiter_unit
  import swr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,   // frame_control[7:0], line_byte[15:8]
  input  logic [1:0]              s_axis_tuser,   // op[1:0]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,   // outcome[2:0], zeros above
  output logic [1:0]              m_axis_tuser,   // transmit[0], finished[1]
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    step;
  logic    out_space;
  logic    has_result;
  result_t result;
  result_t out_result;

  assign in_item.op            = s_axis_tuser;
  assign in_item.frame_control = s_axis_tdata[7:0];
  assign in_item.line_byte     = s_axis_tdata[15:8];

  assign step = cur_valid && out_space;

  swr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  swr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (step),
    .item_o  (cur_item)
  );

  swr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (step),
    .item_i       (cur_item),
    .has_result_o (has_result),
    .result_o     (result)
  );

  swr_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (has_result),
    .result_i (result),
    .space_o  (out_space),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {5'd0, out_result.outcome};
  assign m_axis_tuser = {out_result.finished, out_result.transmit};

endmodule

// ===== rtl/swr_checker.sv =====
// Port-level checks for the stop-and-wait reply waiter, bound to the top level.
module swr_checker
  import swr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Without finished the outcome field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == 8'd0)
    else $error("outcome set on a beat that does not finish");

  // Transmit together with finished only happens for a UA frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1] |->
      m_axis_tdata[2:0] == OC_UA_SENT)
    else $error("transmit and finish without the UA outcome");

  // A finish without transmit never carries the UA-sent or an unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0] |->
      m_axis_tdata[2:0] != OC_UA_SENT && m_axis_tdata[2:0] != 3'd7)
    else $error("bad outcome on a reply or exhaustion beat");

  // Nothing is offered right after reset is released.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered straight out of reset");

endmodule

bind stop_and_wait_reply_waiter_unit swr_checker u_swr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
